[rtl/fird_pkg.sv]
// ----------------------------------------------------------------------------
// fird_pkg
// Shared types, constants and the coefficient table of the 19-tap
// smoothing differentiator.
// ----------------------------------------------------------------------------
package fird_pkg;

	localparam int TAPS      = 19;
	localparam int ADDR_BITS = 5;
	localparam int COEF_BITS = 17;
	localparam int OUT_BITS  = 43;

	typedef logic [ADDR_BITS-1:0]        tap_idx_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic signed [OUT_BITS-1:0]  sum_t;

	// control for the shared multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
		logic last;
	} mac_ctl_t;

	// coefficients, oldest sample first
	function automatic coef_t coef_at(tap_idx_t idx);
		coef_t c;
		unique case (idx)
			5'd0:    c = -17'sd36894;
			5'd1:    c = -17'sd45552;
			5'd2:    c = -17'sd28028;
			5'd3:    c = -17'sd7056;
			5'd4:    c =  17'sd2700;
			5'd5:    c =  17'sd3152;
			5'd6:    c =  17'sd1281;
			5'd7:    c =  17'sd264;
			5'd8:    c =  17'sd23;
			5'd9:    c =  17'sd0;
			5'd10:   c = -17'sd23;
			5'd11:   c = -17'sd264;
			5'd12:   c = -17'sd1281;
			5'd13:   c = -17'sd3152;
			5'd14:   c = -17'sd2700;
			5'd15:   c =  17'sd7056;
			5'd16:   c =  17'sd28028;
			5'd17:   c =  17'sd45552;
			5'd18:   c =  17'sd36894;
			default: c = '0;
		endcase
		return c;
	endfunction

	// ring position advance with wrap
	function automatic tap_idx_t next_idx(tap_idx_t i);
		return (i == tap_idx_t'(TAPS - 1)) ? '0 : i + tap_idx_t'(1);
	endfunction

endpackage

[rtl/fir_derivative_19tap.sv]
// ----------------------------------------------------------------------------
// fir_derivative_19tap
// 19-tap smoothing differentiator: one multiplier walks the ring once per
// sample except on a refill, oldest to newest, under a small sequencer.
// ----------------------------------------------------------------------------
// normal request: walk the ring; no new request until the result is registered
// first request or restart: ring refill, one entry a cycle, then a zero result
// throughput is set by the single multiplier stepping over the 19 taps
// in_stall is high from accept until the result enters the output register
// arst_n clears the sequencer, write position, primed flag and output valid
module fir_derivative_19tap #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output fird_pkg::sum_t                slope_sum
);
	import fird_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FILL  = 3'd1;
	localparam logic [2:0] ST_RUN   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                    state_q;
	tap_idx_t                      cnt_q;
	tap_idx_t                      wpos_q;
	tap_idx_t                      rptr_q;
	logic                          primed_q;
	logic                          zero_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          v_s1;
	logic                          last_s1;
	coef_t                         coef_s1;
	logic                          out_valid_q;
	sum_t                          slope_sum_q;

	logic                          accept;
	logic                          refill;
	logic                          slot_free;
	logic                          filling;
	logic                          hist_we;
	tap_idx_t                      hist_waddr;
	logic signed [SAMPLE_BITS-1:0] hist_wdata;
	logic signed [SAMPLE_BITS-1:0] hist_rdata;
	mac_ctl_t                      mac_ctl;
	sum_t                          mac_acc;
	logic                          mac_done;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign refill    = !primed_q || restart;
	assign slot_free = !out_valid_q || !out_stall;
	assign filling   = (state_q == ST_FILL);

	// normal request writes the newest sample at once, refill sweeps the ring
	assign hist_we    = (accept && !refill) || filling;
	assign hist_waddr = filling ? cnt_q : wpos_q;
	assign hist_wdata = filling ? sample_q : sample;

	assign mac_ctl.clear = accept && !refill;
	assign mac_ctl.valid = v_s1;
	assign mac_ctl.last  = last_s1;

	fird_hist #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (state_q == ST_RUN),
		.raddr (rptr_q),
		.rdata (hist_rdata)
	);

	fird_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.data   (hist_rdata),
		.coef   (coef_s1),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			wpos_q      <= '0;
			rptr_q      <= '0;
			primed_q    <= 1'b0;
			zero_q      <= 1'b0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1    <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && (cnt_q == tap_idx_t'(TAPS - 1));
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (refill) begin
							wpos_q   <= '0;
							primed_q <= 1'b1;
							state_q  <= ST_FILL;
						end else begin
							// oldest entry sits just past the newest
							wpos_q  <= next_idx(wpos_q);
							rptr_q  <= next_idx(wpos_q);
							state_q <= ST_RUN;
						end
					end
				end
				ST_FILL: begin
					cnt_q <= next_idx(cnt_q);
					if (cnt_q == tap_idx_t'(TAPS - 1)) begin
						zero_q  <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_RUN: begin
					rptr_q <= next_idx(rptr_q);
					cnt_q  <= next_idx(cnt_q);
					if (cnt_q == tap_idx_t'(TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						zero_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		coef_s1 <= coef_at(cnt_q);
		if (state_q == ST_DONE && slot_free) begin
			slope_sum_q <= zero_q ? '0 : mac_acc;
		end
	end

	assign out_valid = out_valid_q;
	assign slope_sum = slope_sum_q;

`ifndef NO_ASSERTIONS
	a_wpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		wpos_q <= tap_idx_t'(TAPS - 1))
		else $error("write position out of range");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == ST_DRAIN))
		else $error("accumulator finished outside drain");

	a_refill_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && refill) |=> (state_q == ST_FILL && wpos_q == '0 && primed_q))
		else $error("refill request did not start a ring fill");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && slot_free && zero_q) |=> (out_valid && slope_sum == '0))
		else $error("refill result is not zero");
`endif

endmodule

[rtl/fird_hist.sv]
// ----------------------------------------------------------------------------
// fird_hist
// Sample history ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fird_hist #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          we,
	input  fird_pkg::tap_idx_t            waddr,
	input  logic signed [SAMPLE_BITS-1:0] wdata,
	input  logic                          re,
	input  fird_pkg::tap_idx_t            raddr,
	output logic signed [SAMPLE_BITS-1:0] rdata
);
	import fird_pkg::*;

	logic signed [SAMPLE_BITS-1:0] mem_q [TAPS];
	logic signed [SAMPLE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/fird_mac.sv]
// ----------------------------------------------------------------------------
// fird_mac
// Shared multiply-accumulate unit: registered product, then a 43-bit
// wrapping accumulator.
// ----------------------------------------------------------------------------
module fird_mac #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fird_pkg::mac_ctl_t            ctl,
	input  logic signed [SAMPLE_BITS-1:0] data,
	input  fird_pkg::coef_t               coef,
	output fird_pkg::sum_t                acc,
	output logic                          done
);
	import fird_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int EXT_BITS  = (PROD_BITS > OUT_BITS) ? PROD_BITS : OUT_BITS;

	logic signed [PROD_BITS-1:0] prod_s2;
	logic signed [EXT_BITS-1:0]  prod_ext;
	logic                        v_s2;
	logic                        last_s2;
	sum_t                        acc_q;
	logic                        done_q;

	// sign extend, then keep the low bits: the sum wraps at the output width
	assign prod_ext = prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s2    <= ctl.valid;
			last_s2 <= ctl.valid && ctl.last;
			done_q  <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= data * coef;
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + sum_t'(prod_ext[OUT_BITS-1:0]);
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule
